/* sv/sem_pkg.sv */
package sem_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int QUEUE_DEPTH    = 2;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_idx;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [20:0] SQ_SAT_LIMIT = 21'd65280;
    localparam logic [7:0]  PIX_MAX      = 8'd255;

    typedef logic [23:0] t_rgb;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_of_frame;
    } t_pix_out;

    typedef struct packed {
        t_rgb [2:0][2:0] pix;
        logic            last;
    } t_job;

endpackage

/* sv/sem_queue.sv */
module sem_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [PW-1:0]  r_rd;
    logic [PW-1:0]  r_wr;
    logic [CNW-1:0] r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (32'(r_cnt) == DEPTH);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* sv/sem_front.sv */
module sem_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  sem_pkg::t_pix_in                 i_pix,
    input  logic                             i_cfg_valid,
    input  logic [sem_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_job_room,
    output logic                             o_job_push,
    output sem_pkg::t_job                    o_job
);
    import sem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    typedef enum logic {F_IDLE, F_PROC} t_fstate;

    t_fstate                 r_state;
    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [CW-1:0]           r_in_col;
    logic [RW-1:0]           r_in_row;
    logic [CW-1:0]           r_out_col;
    logic [HW-1:0]           r_out_row;
    t_rgb                    r_win [3][3];
    t_rgb                    n_win [3][3];
    t_rgb                    sel   [3][3];
    t_rgb                    r_px;
    logic [47:0]             r_line [MAX_WIDTH];
    logic [47:0]             r_line_rd;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          pixel_phase;
    logic          accept;
    logic          wrap;
    logic          plain;
    logic          emit;
    logic          top_z;
    logic          bot_z;
    logic          left_z;
    logic          right_z;

    always_comb begin
        if (r_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        if (r_height == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_height);
        end
    end

    assign pixel_phase = 32'(r_in_row) < 32'(eff_h);
    assign o_full      = (r_state != F_IDLE) || !i_job_room;
    assign accept      = i_push && !o_full;

    assign wrap    = (r_in_col == '0) && (32'(r_in_row) >= 2);
    assign plain   = (r_in_col != '0) && (32'(r_in_row) >= 1);
    assign emit    = wrap || plain;
    assign top_z   = (r_out_row == '0);
    assign bot_z   = (32'(r_out_row) == 32'(eff_h) - 1);
    assign left_z  = (r_out_col == '0);
    assign right_z = (32'(r_out_col) == 32'(eff_w) - 1);

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = r_line_rd[47:24];
        n_win[1][2] = r_line_rd[23:0];
        n_win[2][2] = r_px;
        for (int r = 0; r < 3; r++) begin
            sel[r][0] = wrap ? r_win[r][1] : n_win[r][0];
            sel[r][1] = wrap ? r_win[r][2] : n_win[r][1];
            sel[r][2] = wrap ? '0 : n_win[r][2];
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r == 0 && top_z) || (r == 2 && bot_z) ||
                    (c == 0 && left_z) || (c == 2 && right_z)) begin
                    o_job.pix[r][c] = '0;
                end else begin
                    o_job.pix[r][c] = sel[r][c];
                end
            end
        end
        o_job.last = bot_z && right_z;
    end

    assign o_job_push = (r_state == F_PROC) && emit;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_rd <= r_line[r_in_col];
        end
        if (r_state == F_PROC) begin
            r_line[r_in_col] <= {r_line_rd[23:0], r_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_px      <= '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_cfg_valid &&
                     (i_cfg_idx == CFG_IMAGE_WIDTH || i_cfg_idx == CFG_IMAGE_HEIGHT)) begin
            if (i_cfg_idx == CFG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data[WIDTH_REG_W-1:0];
            end else begin
                r_height <= i_cfg_data[HEIGHT_REG_W-1:0];
            end
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept && !(i_pix.cmd == CMD_FLUSH && pixel_phase)) begin
                        r_state <= F_PROC;
                        if (pixel_phase) begin
                            r_px <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
                        end else begin
                            r_px <= '0;
                        end
                    end
                end
                F_PROC: begin
                    r_state <= F_IDLE;
                    if (emit && o_job.last) begin
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                        for (int r = 0; r < 3; r++) begin
                            for (int c = 0; c < 3; c++) begin
                                r_win[r][c] <= '0;
                            end
                        end
                    end else begin
                        r_win <= n_win;
                        if (32'(r_in_col) + 1 >= 32'(eff_w)) begin
                            r_in_col <= '0;
                            r_in_row <= r_in_row + 1'b1;
                        end else begin
                            r_in_col <= r_in_col + 1'b1;
                        end
                        if (emit) begin
                            if (right_z) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + 1'b1;
                            end else begin
                                r_out_col <= r_out_col + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

/* sv/sem_back.sv */
module sem_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    input  sem_pkg::t_job     i_job,
    input  logic              i_res_room,
    output logic              o_res_push,
    output sem_pkg::t_pix_out o_res
);
    import sem_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_SUM, B_SQ, B_ROOT, B_DONE} t_bstate;

    t_bstate            r_state;
    t_job               r_job;
    logic signed [11:0] r_gx [3];
    logic signed [11:0] r_gy [3];
    logic [20:0]        r_sq [3];
    logic [7:0]         r_root [3];
    logic [7:0]         r_bit;

    logic signed [11:0] n_gx [3];
    logic signed [11:0] n_gy [3];
    logic signed [11:0] p [3][3][3];
    logic [7:0]         t [3];
    logic [7:0]         res [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    p[ch][r][c] = $signed({4'b0, r_job.pix[r][c][23-8*ch -: 8]});
                end
            end
            n_gx[ch] = (p[ch][0][2] - p[ch][0][0]) + ((p[ch][1][2] - p[ch][1][0]) <<< 1)
                     + (p[ch][2][2] - p[ch][2][0]);
            n_gy[ch] = (p[ch][2][0] - p[ch][0][0]) + ((p[ch][2][1] - p[ch][0][1]) <<< 1)
                     + (p[ch][2][2] - p[ch][0][2]);
            t[ch] = r_root[ch] | r_bit;
            if (r_sq[ch] > SQ_SAT_LIMIT) begin
                res[ch] = PIX_MAX;
            end else if (r_sq[ch] > 21'(17'(r_root[ch] * r_root[ch]) + 17'(r_root[ch]))) begin
                res[ch] = r_root[ch] + 1'b1;
            end else begin
                res[ch] = r_root[ch];
            end
        end
    end

    assign o_job_pop  = (r_state == B_IDLE) && i_job_valid && i_res_room;
    assign o_res_push = (r_state == B_DONE);
    assign o_res      = '{red_out: res[0], green_out: res[1], blue_out: res[2],
                          last_of_frame: r_job.last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_bit   <= '0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (o_job_pop) begin
                        r_job   <= i_job;
                        r_state <= B_SUM;
                    end
                end
                B_SUM: begin
                    r_gx    <= n_gx;
                    r_gy    <= n_gy;
                    r_state <= B_SQ;
                end
                B_SQ: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_sq[ch]   <= 21'(r_gx[ch] * r_gx[ch]) + 21'(r_gy[ch] * r_gy[ch]);
                        r_root[ch] <= '0;
                    end
                    r_bit   <= 8'h80;
                    r_state <= B_ROOT;
                end
                B_ROOT: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        if ({5'b0, 16'(t[ch] * t[ch])} <= r_sq[ch]) begin
                            r_root[ch] <= t[ch];
                        end
                    end
                    r_bit <= r_bit >> 1;
                    if (r_bit[0]) begin
                        r_state <= B_DONE;
                    end
                end
                B_DONE: r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

/* sv/sobel_edge_magnitude_rgb_core.sv */
// Path: an accepted item is registered in the front; a result that it releases passes the job queue,
// the back states (B_SUM, B_SQ, B_ROOT, B_DONE) and the result queue to the result ports.
// The front finishes each item (line store read, then window update) before taking the next;
// the back works on one result at a time (gradient sum, square, 8 root steps, rounding).
// Reset: synchronous, active low; counters, window and queues clear, registers return to
// 640 x 480. Line stores are not cleared and take items at once after reset.
module sobel_edge_magnitude_rgb_core #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  sem_pkg::t_pix_in               i_pix,
    output logic                           empty,
    input  logic                           pop,
    output sem_pkg::t_pix_out              o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sem_pkg::*;

    localparam int JW = $bits(t_job);
    localparam int OW = $bits(t_pix_out);

    t_job          job_in;
    logic          job_push;
    logic          job_full;
    logic          job_empty;
    logic          job_pop;
    logic [JW-1:0] job_q;
    t_pix_out      res_in;
    logic          res_push;
    logic          res_full;
    logic [OW-1:0] res_q;

    assign o_cfg_ready = 1'b1;

    sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_pix      (i_pix),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_job_room (!job_full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    sem_queue #(.W(JW), .DEPTH(QUEUE_DEPTH)) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_data (job_in),
        .i_pop  (job_pop),
        .o_data (job_q),
        .o_empty(job_empty),
        .o_full (job_full)
    );

    sem_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(!job_empty),
        .o_job_pop  (job_pop),
        .i_job      (t_job'(job_q)),
        .i_res_room (!res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    sem_queue #(.W(OW), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .i_pop  (pop),
        .o_data (res_q),
        .o_empty(empty),
        .o_full (res_full)
    );

    assign o_res = t_pix_out'(res_q);

endmodule

/* sv/sem_checker.sv */
module sem_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input sem_pkg::t_pix_in  i_pix,
    input logic              empty,
    input logic              pop
);
    import sem_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results visible after reset");

    a_reset_room: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked after reset");

    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_pix.cmd == CMD_PIXEL) |=> full)
        else $error("pixel transaction not held for line store update");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && $past(empty) && $past(!i_rst_n)) |-> 1'b0)
        else $error("result popped right after reset");

endmodule

bind sobel_edge_magnitude_rgb_core sem_checker u_sem_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .push   (push),
    .full   (full),
    .i_pix  (i_pix),
    .empty  (empty),
    .pop    (pop)
);

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    localparam int                   STALL_LIMIT   = 3000;
    localparam int                   DRAIN_CYCLES  = 40;
    localparam int                   LONG_HOLD     = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_pix_in               i_pix;
    logic                  empty;
    logic                  pop;
    t_pix_out              o_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sobel_edge_magnitude_rgb_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_pix       (i_pix),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // edge magnitude predictor state
    t_rgb        upper_store [MAX_WIDTH_DEF];
    t_rgb        middle_store[MAX_WIDTH_DEF];
    t_rgb        nbhd[3][3];
    int unsigned width_reg, height_reg;
    int unsigned in_col, in_row, out_col, out_row;
    int          kern_gx[3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
    int          kern_gy[3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

    t_pix_out    pending_pixels[$];
    int          error_count;
    int          items_sent;
    int          idle_cycles;
    int          hold_left;
    int          pop_gap;
    bit          calm;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic int unsigned frame_width();
        if (width_reg < 1) return 1;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return width_reg;
    endfunction

    function automatic int unsigned frame_height();
        if (height_reg < 1) return 1;
        if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
        return height_reg;
    endfunction

    function automatic void restart_frame();
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                nbhd[r][c] = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic logic [7:0] rounded_root(int unsigned s);
        int unsigned r;
        int unsigned t;
        if (s > 65280) return PIX_MAX;
        r = 0;
        for (int b = 7; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= s) r = t;
        end
        if (s > r * r + r) r++;
        return (r > 255) ? PIX_MAX : r[7:0];
    endfunction

    // wrapped: neighbourhood column c comes from window column c+1
    function automatic t_pix_out gradient_pixel(bit wrapped, int unsigned w, int unsigned h);
        int       gx[3];
        int       gy[3];
        int       src;
        int       v;
        t_pix_out res;
        gx = '{0, 0, 0};
        gy = '{0, 0, 0};
        for (int r = 0; r < 3; r++) begin
            if (r == 0 && out_row == 0) continue;
            if (r == 2 && out_row == h - 1) continue;
            for (int c = 0; c < 3; c++) begin
                src = wrapped ? c + 1 : c;
                if (src > 2) continue;
                if (c == 0 && out_col == 0) continue;
                if (c == 2 && out_col == w - 1) continue;
                for (int ch = 0; ch < 3; ch++) begin
                    v = (nbhd[r][src] >> (16 - 8 * ch)) & 8'hFF;
                    gx[ch] += v * kern_gx[r][c];
                    gy[ch] += v * kern_gy[r][c];
                end
            end
        end
        res.red_out       = rounded_root(gx[0] * gx[0] + gy[0] * gy[0]);
        res.green_out     = rounded_root(gx[1] * gx[1] + gy[1] * gy[1]);
        res.blue_out      = rounded_root(gx[2] * gx[2] + gy[2] * gy[2]);
        res.last_of_frame = (out_row == h - 1 && out_col == w - 1);
        return res;
    endfunction

    function automatic void predict_pixel(t_pix_in p);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        bit          in_pixels;
        bit          emit;
        t_rgb        px;
        t_rgb        up;
        t_rgb        mid;
        t_pix_out    res;
        w = frame_width();
        h = frame_height();
        in_pixels = in_row < h;
        emit = 1'b0;
        if (p.cmd == CMD_FLUSH && in_pixels) return;
        px = (in_pixels && p.cmd == CMD_PIXEL) ? {p.red_in, p.green_in, p.blue_in} : '0;
        col = in_col % MAX_WIDTH_DEF;
        up  = upper_store[col];
        mid = middle_store[col];
        if (in_col == 0 && in_row >= 2) begin
            res = gradient_pixel(1'b1, w, h);
            emit = 1'b1;
        end
        for (int r = 0; r < 3; r++) begin
            nbhd[r][0] = nbhd[r][1];
            nbhd[r][1] = nbhd[r][2];
        end
        nbhd[0][2] = up;
        nbhd[1][2] = mid;
        nbhd[2][2] = px;
        upper_store[col]  = mid;
        middle_store[col] = px;
        if (in_col != 0 && in_row >= 1) begin
            res = gradient_pixel(1'b0, w, h);
            emit = 1'b1;
        end
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end
        if (!emit) return;
        pending_pixels.push_back(res);
        if (res.last_of_frame) begin
            restart_frame();
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_pix_in make_pixel(int style);
        t_pix_in p;
        p.cmd = CMD_PIXEL;
        case (style)
            1: begin
                p.red_in   = $urandom_range(0, 1) ? PIX_MAX : 8'd0;
                p.green_in = $urandom_range(0, 1) ? PIX_MAX : 8'd0;
                p.blue_in  = $urandom_range(0, 1) ? PIX_MAX : 8'd0;
            end
            2: begin
                p.red_in   = 8'($urandom_range(0, 7));
                p.green_in = 8'($urandom_range(0, 7));
                p.blue_in  = 8'($urandom_range(0, 7));
            end
            default: begin
                p.red_in   = 8'($urandom);
                p.green_in = 8'($urandom);
                p.blue_in  = 8'($urandom);
            end
        endcase
        return p;
    endfunction

    function automatic t_pix_in make_flush();
        t_pix_in p;
        p = make_pixel(0);
        p.cmd = CMD_FLUSH;
        return p;
    endfunction

    task automatic send_item(t_pix_in p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push  <= 1'b1;
        i_pix <= p;
        do @(posedge i_clk); while (full);
        predict_pixel(p);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_IMAGE_WIDTH) begin
            width_reg = data & 13'h7FF;
            restart_frame();
        end else if (idx == CFG_IMAGE_HEIGHT) begin
            height_reg = data;
            restart_frame();
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_size(int w, int h);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    // noisy: stray flushes in the pixel phase and pixels in the drain phase
    task automatic run_frame(int style, bit noisy);
        int unsigned w;
        int unsigned h;
        w = frame_width();
        h = frame_height();
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) send_item(make_flush());
            send_item(make_pixel(style));
        end
        for (int i = 0; i <= w; i++)
            send_item((noisy && $urandom_range(0, 2) == 0) ? make_pixel(0) : make_flush());
    endtask

    task automatic test_directed_frames();
        calm = 1'b1;
        set_size(3, 3);
        run_frame(1, 1'b0);
        set_size(1, 1);
        run_frame(0, 1'b0);
        calm = 1'b0;
    endtask

    task automatic test_stray_items();
        set_size(4, 2);
        send_item(make_flush());
        send_item(make_flush());
        run_frame(0, 1'b1);
    endtask

    task automatic test_size_limits();
        set_size(0, 0);
        run_frame(0, 1'b0);
        set_size(2, 1);
        run_frame(1, 1'b0);
        set_size(1, 2);
        run_frame(0, 1'b0);
        set_size(13'h1FFF, 1);
        repeat (MAX_WIDTH_DEF) send_item(make_pixel(2));
        repeat (3) send_item(make_flush());
        set_size(1, 13'h1FFF);
        repeat (20) send_item(make_pixel(2));
    endtask

    task automatic test_restart_and_spare_index();
        set_size(5, 4);
        repeat (13) send_item(make_pixel(0));
        write_reg(CFG_IDX_SPARE, 13'h1FFF);
        repeat (4) send_item(make_pixel(0));
        write_reg(CFG_IMAGE_HEIGHT, 13'd3);
        run_frame(0, 1'b0);
        write_reg(CFG_IDX_SPARE, 13'd0);
        run_frame(1, 1'b0);
    endtask

    task automatic test_backpressure();
        set_size(6, 6);
        calm = 1'b1;
        hold_left = LONG_HOLD;
        run_frame(0, 1'b0);
        calm = 1'b0;
        wait_drain();
        run_frame(0, 1'b0);
    endtask

    task automatic test_random_frames();
        int target;
        target = items_sent + 150;
        while (items_sent < target) begin
            if ($urandom_range(0, 4) == 0)
                set_size($urandom_range(11, 40), $urandom_range(1, 8));
            else
                set_size($urandom_range(1, 10), $urandom_range(1, 8));
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 20)) send_item(make_pixel(0));
            else
                run_frame($urandom_range(0, 3), $urandom_range(0, 3) == 0);
        end
        calm = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else if (pop_gap > 0) begin
            pop <= 1'b0;
            pop_gap--;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) pop_gap = pick_gap();
        end
    end

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pix_out exp_px;
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_res);
                error_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                check_field("red_out", exp_px.red_out, o_res.red_out);
                check_field("green_out", exp_px.green_out, o_res.green_out);
                check_field("blue_out", exp_px.blue_out, o_res.blue_out);
                check_field("last_of_frame", exp_px.last_of_frame, o_res.last_of_frame);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)
                || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_pix       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_idx   = CFG_IMAGE_WIDTH;
        i_cfg_data  = '0;
        error_count = 0;
        items_sent  = 0;
        idle_cycles = 0;
        hold_left   = 0;
        pop_gap     = 0;
        calm        = 1'b0;
        width_reg   = WIDTH_RESET;
        height_reg  = HEIGHT_RESET;
        for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
            upper_store[i]  = '0;
            middle_store[i] = '0;
        end
        restart_frame();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_frames();
        test_stray_items();
        test_restart_and_spare_index();
        test_backpressure();
        test_size_limits();
        test_random_frames();
        wait_drain();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
